[hw/rtl/assert_macros.svh]
// assertion helpers used by the converter top
// all checks sample on clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcconv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcconv_pkg
// Constants and the type K linearization table for the thermocouple converter.
// ----------------------------------------------------------------------------
package tcconv_pkg;

  // number of table points in use and number stored in the rom
  localparam int TABLE_ENTRIES = 216;
  localparam int ROM_SIZE      = 216;

  localparam logic [15:0] OOR_VALUE   = 16'hFFFF;
  localparam logic [16:0] ROUND_HALF  = 17'd128;

  // highest segment index that still has a right-hand point
  localparam logic [7:0] SEG_LAST     = 8'(TABLE_ENTRIES - 2);
  // index of the last table point
  localparam logic [7:0] IDX_LAST     = 8'(TABLE_ENTRIES - 1);

  // action codes carried on tuser
  localparam logic ACT_UV_TO_TEMP = 1'b0;
  localparam logic ACT_TEMP_TO_UV = 1'b1;

  // temperature in 1/32 degree at each multiple of 256 microvolts
  localparam logic [15:0] TK_ROM [0:ROM_SIZE-1] = '{
    16'd0, 16'd207, 16'd412, 16'd616, 16'd819, 16'd1021, 16'd1221, 16'd1421,
    16'd1620, 16'd1818, 16'd2016, 16'd2214, 16'd2411, 16'd2608, 16'd2806,
    16'd3003, 16'd3201, 16'd3399, 16'd3598, 16'd3797, 16'd3997, 16'd4198,
    16'd4400, 16'd4602, 16'd4805, 16'd5009, 16'd5214, 16'd5418, 16'd5623,
    16'd5829, 16'd6034, 16'd6239, 16'd6444, 16'd6650, 16'd6853, 16'd7058,
    16'd7261, 16'd7464, 16'd7666, 16'd7869, 16'd8070, 16'd8270, 16'd8471,
    16'd8670, 16'd8869, 16'd9068, 16'd9266, 16'd9464, 16'd9662, 16'd9860,
    16'd10057, 16'd10253, 16'd10450, 16'd10646, 16'd10842, 16'd11038,
    16'd11234, 16'd11429, 16'd11624, 16'd11819, 16'd12014, 16'd12209,
    16'd12403, 16'd12597, 16'd12791, 16'd12985, 16'd13179, 16'd13373,
    16'd13566, 16'd13760, 16'd13953, 16'd14146, 16'd14339, 16'd14532,
    16'd14724, 16'd14917, 16'd15110, 16'd15303, 16'd15495, 16'd15687,
    16'd15880, 16'd16072, 16'd16264, 16'd16456, 16'd16649, 16'd16840,
    16'd17033, 16'd17225, 16'd17417, 16'd17609, 16'd17801, 16'd17993,
    16'd18186, 16'd18378, 16'd18570, 16'd18763, 16'd18955, 16'd19148,
    16'd19340, 16'd19533, 16'd19726, 16'd19919, 16'd20112, 16'd20305,
    16'd20499, 16'd20692, 16'd20886, 16'd21080, 16'd21274, 16'd21468,
    16'd21662, 16'd21858, 16'd22052, 16'd22247, 16'd22443, 16'd22638,
    16'd22834, 16'd23030, 16'd23226, 16'd23422, 16'd23619, 16'd23816,
    16'd24014, 16'd24211, 16'd24409, 16'd24607, 16'd24806, 16'd25004,
    16'd25203, 16'd25403, 16'd25602, 16'd25802, 16'd26003, 16'd26204,
    16'd26404, 16'd26605, 16'd26807, 16'd27009, 16'd27211, 16'd27413,
    16'd27617, 16'd27820, 16'd28023, 16'd28227, 16'd28432, 16'd28636,
    16'd28841, 16'd29047, 16'd29252, 16'd29458, 16'd29664, 16'd29871,
    16'd30078, 16'd30285, 16'd30493, 16'd30701, 16'd30909, 16'd31118,
    16'd31327, 16'd31536, 16'd31746, 16'd31957, 16'd32167, 16'd32378,
    16'd32589, 16'd32801, 16'd33013, 16'd33226, 16'd33439, 16'd33652,
    16'd33865, 16'd34079, 16'd34294, 16'd34508, 16'd34724, 16'd34940,
    16'd35155, 16'd35372, 16'd35590, 16'd35807, 16'd36025, 16'd36244,
    16'd36463, 16'd36682, 16'd36903, 16'd37123, 16'd37344, 16'd37567,
    16'd37789, 16'd38012, 16'd38235, 16'd38459, 16'd38684, 16'd38910,
    16'd39137, 16'd39364, 16'd39591, 16'd39820, 16'd40049, 16'd40279,
    16'd40510, 16'd40741, 16'd40973, 16'd41207, 16'd41440, 16'd41675,
    16'd41910, 16'd42146, 16'd42383, 16'd42621, 16'd42859, 16'd43098,
    16'd43337, 16'd43578, 16'd43818, 16'd44059
  };

  // table read, indexes past the rom return the last point
  function automatic logic [15:0] rom_read(input logic [7:0] idx);
    logic [7:0] i;
    i = idx;
    if (i >= 8'(ROM_SIZE - 1)) begin
      i = 8'(ROM_SIZE - 1);
    end
    return TK_ROM[i];
  endfunction

endpackage

[hw/rtl/thermocouple_table_convert_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_table_convert_top
// Type K thermocouple linearization: microvolts to temperature by table
// interpolation, temperature to microvolts by table search and division.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tuser
//  in_     | slave     | [15:0] value   | [0] action
//  out_    | master    | [15:0] result  | [0] out_of_range
//
//  microvolts to temperature: range check, interpolation, then the result register
//  temperature to microvolts: range check, then the table search
//  (one table point per cycle) plus a 16-step restoring division
//  one item at a time; in_tready is high only while the sequencer is idle
//  the result register holds until its transfer, a new input is taken meanwhile
//  synchronous active-low reset clears the sequencer and out_tvalid only
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermocouple_table_convert_top
  import tcconv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result
  output logic [0:0]  out_tuser   // [0] out_of_range
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_INTERP = 6'b000100,
    S_SEARCH = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_OUT    = 6'b100000
  } tc_state_t;

  tc_state_t   state_r, state_nxt;
  logic        act_r, act_nxt;
  logic [15:0] val_r, val_nxt;      // input value, then dividend / quotient
  logic [15:0] a_r, a_nxt;          // lower table point
  logic [15:0] b_r, b_nxt;          // upper table point
  logic [7:0]  u_r, u_nxt;          // search index
  logic [7:0]  rem_r, rem_nxt;      // division remainder
  logic [3:0]  cnt_r, cnt_nxt;      // division step count
  logic [15:0] res_r, res_nxt;
  logic        oor_r, oor_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;
  logic        out_oor_r, out_oor_nxt;

  logic        in_xfer;
  logic        out_xfer;
  logic [7:0]  seg;
  logic [7:0]  frac;
  logic [7:0]  k;
  logic [15:0] prod;
  logic [16:0] rounded;
  logic [15:0] tbl_u;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic [15:0] quot;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  // shared datapath pieces
  assign seg     = val_r[15:8];
  assign frac    = val_r[7:0];
  assign k       = 8'(b_r - a_r);
  assign prod    = k * frac;
  assign rounded = {1'b0, prod} + ROUND_HALF;
  assign tbl_u   = rom_read(u_r);
  assign trial   = {rem_r, val_r[15]};
  assign diff    = trial - {1'b0, k};
  assign quot    = (k == 8'd0) ? 16'd0 : val_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    u_nxt         = u_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_oor_nxt   = out_oor_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt   = in_tuser[0];
          val_nxt   = in_tdata;
          state_nxt = S_CHECK;
        end
      end

      // range check and first table reads
      S_CHECK: begin
        oor_nxt = 1'b0;
        if (act_r == ACT_UV_TO_TEMP) begin
          if (seg > SEG_LAST) begin
            oor_nxt   = 1'b1;
            res_nxt   = OOR_VALUE;
            state_nxt = S_OUT;
          end else begin
            a_nxt     = rom_read(seg);
            b_nxt     = rom_read(seg + 8'd1);
            state_nxt = S_INTERP;
          end
        end else begin
          if (rom_read(IDX_LAST) < val_r) begin
            oor_nxt   = 1'b1;
            res_nxt   = OOR_VALUE;
            state_nxt = S_OUT;
          end else begin
            a_nxt     = 16'd0;
            u_nxt     = 8'd1;
            state_nxt = S_SEARCH;
          end
        end
      end

      // linear interpolation with rounding
      S_INTERP: begin
        res_nxt   = a_r + {8'd0, rounded[15:8]};
        state_nxt = S_OUT;
      end

      // one table point per cycle until it reaches the input
      S_SEARCH: begin
        if (tbl_u >= val_r) begin
          b_nxt     = tbl_u;
          // dividend is (t - a) << 8 plus half the interval
          val_nxt   = {8'(val_r - a_r), 8'd0} + {8'd0, 1'b0, 7'(8'(tbl_u - a_r) >> 1)};
          rem_nxt   = 8'd0;
          cnt_nxt   = 4'd0;
          state_nxt = S_DIVIDE;
        end else begin
          a_nxt = tbl_u;
          u_nxt = u_r + 8'd1;
        end
      end

      // restoring division, one quotient bit per cycle
      S_DIVIDE: begin
        if (!diff[8]) begin
          rem_nxt = diff[7:0];
          val_nxt = {val_r[14:0], 1'b1};
        end else begin
          rem_nxt = trial[7:0];
          val_nxt = {val_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_OUT;
          res_nxt   = {8'(u_r - 8'd1), 8'd0};
        end
      end

      // load the result register once it is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          if (act_r == ACT_TEMP_TO_UV && !oor_r) begin
            out_data_nxt = res_r + quot;
          end else begin
            out_data_nxt = res_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    u_r        <= u_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  `TC_ASSERT_NOW(a_oor_value, out_valid_r && out_oor_r, out_data_r == OOR_VALUE, "out of range result is not all ones")
  `TC_ASSERT_NOW(a_search_bound, state_r == S_SEARCH, u_r <= IDX_LAST, "table search ran past the last point")
  `TC_ASSERT_NOW(a_div_nonzero, state_r == S_DIVIDE, b_r != a_r, "division by a zero interval")
  `TC_ASSERT_NEXT(a_accept_check, in_tvalid && in_tready, state_r == S_CHECK, "accepted input did not start a conversion")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the type K thermocouple converter in both directions: table
// interpolation from microvolts and table search plus division from
// temperature. Each accepted input is run through a local model of the
// conversion, and each result transfer is compared with the oldest pending
// expectation. Both stream sides idle in random bursts, and a long receiver
// hold-off forces the converter to back up its input.
// ----------------------------------------------------------------------------
module tb_top;
  import tcconv_pkg::*;

  localparam int N_RANDOM    = 1928;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    logic        action;
    logic [15:0] value;
  } conv_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        oor;
  } conv_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] value
  logic [0:0]  in_tuser = '0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] result
  logic [0:0]  out_tuser;       // [0] out_of_range

  conv_req_t pend_q[$];
  conv_res_t conv_expect_q[$];

  int err_cnt    = 0;
  int in_count   = 0;
  int stall_cnt  = 0;
  int in_gap     = 0;
  int out_gap    = 0;
  int hold_left  = 0;
  int hold_next  = 60;
  logic in_acc   = 1'b0;
  logic bursts_on;

  thermocouple_table_convert_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table point with reads past the stored points pinned to the last one
  function automatic int unsigned tk_point(input int unsigned idx);
    int unsigned i;
    i = idx;
    if (i >= ROM_SIZE) begin
      i = ROM_SIZE - 1;
    end
    return int'(TK_ROM[i]);
  endfunction

  // expected result of one conversion
  function automatic conv_res_t predict_conversion(input conv_req_t req);
    conv_res_t   r;
    int unsigned seg, frac, lo, hi, span, idx, quo;
    logic        found;
    r.oor    = 1'b0;
    r.result = '0;
    if (req.action == ACT_UV_TO_TEMP) begin
      seg  = req.value[15:8];
      frac = req.value[7:0];
      if (seg > TABLE_ENTRIES - 2) begin
        r.oor    = 1'b1;
        r.result = OOR_VALUE;
      end else begin
        lo       = tk_point(seg);
        span     = (tk_point(seg + 1) - lo) & 32'hFF;
        r.result = 16'(lo + (((span * frac + 128) >> 8) & 32'hFF));
      end
    end else begin
      if (tk_point(TABLE_ENTRIES - 1) < req.value) begin
        r.oor    = 1'b1;
        r.result = OOR_VALUE;
      end else begin
        // first point at or above the temperature
        lo    = 0;
        hi    = 0;
        idx   = 1;
        found = 1'b0;
        while (idx < TABLE_ENTRIES && !found) begin
          hi = tk_point(idx);
          if (hi >= req.value) begin
            found = 1'b1;
          end else begin
            lo  = hi;
            idx = idx + 1;
          end
        end
        span = (hi - lo) & 32'hFF;
        if (span == 0) begin
          quo = 0;
        end else begin
          quo = ((((req.value - lo) & 32'hFFFF) << 8) + (span >> 1)) / span;
        end
        r.result = 16'(((idx - 1) << 8) + quo);
      end
    end
    return r;
  endfunction

  // random request, mostly inside the table with edges and noise mixed in
  function automatic conv_req_t random_request();
    conv_req_t   req;
    int unsigned sel;
    int          pt;
    req.action = $urandom_range(0, 1) ? ACT_TEMP_TO_UV : ACT_UV_TO_TEMP;
    sel        = $urandom_range(0, 9);
    if (req.action == ACT_UV_TO_TEMP) begin
      if (sel < 7) begin
        req.value = 16'($urandom_range(0, (TABLE_ENTRIES - 1) * 256 - 1));
      end else if (sel < 9) begin
        req.value = {8'($urandom_range(TABLE_ENTRIES - 16, TABLE_ENTRIES)),
                     8'($urandom_range(0, 255))};
      end else begin
        req.value = 16'($urandom);
      end
    end else begin
      if (sel < 6) begin
        req.value = 16'($urandom_range(0, tk_point(TABLE_ENTRIES - 1)));
      end else if (sel < 8) begin
        // on or right beside a table point
        pt        = tk_point($urandom_range(0, TABLE_ENTRIES - 1));
        req.value = 16'(pt + $urandom_range(0, 2) - 1);
      end else begin
        req.value = 16'($urandom);
      end
    end
    return req;
  endfunction

  // random bursts only in part of the run, never near its end
  assign bursts_on = (pend_q.size() > 120) && (((pend_q.size() / 150) % 3) != 0);

  // input driver
  always @(negedge clk) begin
    conv_req_t req;
    logic      nxt_valid;
    if (rst_n) begin
      if (!(in_tvalid && !in_acc)) begin
        nxt_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (pend_q.size() > 0) begin
          if (bursts_on && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(1, 18) - 1;
          end else begin
            req       = pend_q.pop_front();
            in_tdata  <= req.value;
            in_tuser  <= req.action;
            nxt_valid = 1'b1;
          end
        end
        in_tvalid <= nxt_valid;
      end
    end
  end

  // result receiver, with a long hold-off now and then
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && in_count >= hold_next) begin
        hold_left = HOLD_CYCLES;
        hold_next = hold_next + 1140;
      end
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap    = out_gap - 1;
        out_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_gap    = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: check result transfers, then log new input transfers
  always @(posedge clk) begin
    conv_req_t req;
    conv_res_t want;
    in_acc <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (conv_expect_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10) begin
            $display("unexpected result: result=%0d oor=%0b", out_tdata, out_tuser[0]);
          end
        end else begin
          want = conv_expect_q.pop_front();
          if (out_tdata !== want.result || out_tuser[0] !== want.oor) begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= 10) begin
              $display("mismatch: expected result=%0d oor=%0b, got result=%0d oor=%0b",
                       want.result, want.oor, out_tdata, out_tuser[0]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        req.action = in_tuser[0];
        req.value  = in_tdata;
        conv_expect_q.push_back(predict_conversion(req));
        in_count = in_count + 1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // stimulus and end of run
  initial begin
    conv_req_t req;
    // microvolt extremes, rounding edges, last segment and just past it
    req.action = ACT_UV_TO_TEMP;
    foreach (pend_q[i]) begin end
    req.value = 16'h0000; pend_q.push_back(req);
    req.value = 16'h007F; pend_q.push_back(req);
    req.value = 16'h0080; pend_q.push_back(req);
    req.value = 16'h01FF; pend_q.push_back(req);
    req.value = {SEG_LAST, 8'h00}; pend_q.push_back(req);
    req.value = {SEG_LAST, 8'hFF}; pend_q.push_back(req);
    req.value = {SEG_LAST + 8'd1, 8'h00}; pend_q.push_back(req);
    req.value = 16'h5A5A; pend_q.push_back(req);
    req.value = 16'hA5A5; pend_q.push_back(req);
    req.value = 16'hFFFF; pend_q.push_back(req);
    // temperature: zero, on and beside points, last point, past the table
    req.action = ACT_TEMP_TO_UV;
    req.value = 16'd0; pend_q.push_back(req);
    req.value = 16'd1; pend_q.push_back(req);
    req.value = 16'(tk_point(1)); pend_q.push_back(req);
    req.value = 16'(tk_point(1) - 1); pend_q.push_back(req);
    req.value = 16'(tk_point(1) + 1); pend_q.push_back(req);
    req.value = 16'd22000; pend_q.push_back(req);
    req.value = 16'(tk_point(TABLE_ENTRIES - 2)); pend_q.push_back(req);
    req.value = 16'(tk_point(TABLE_ENTRIES - 1)); pend_q.push_back(req);
    req.value = 16'(tk_point(TABLE_ENTRIES - 1) + 1); pend_q.push_back(req);
    req.value = 16'h5555; pend_q.push_back(req);
    req.value = 16'hAAAA; pend_q.push_back(req);
    req.value = 16'hFFFF; pend_q.push_back(req);
    for (int n = 0; n < N_RANDOM; n++) begin
      pend_q.push_back(random_request());
    end

    // hold synchronous reset, then release it on a falling clock edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for the last input transfer, then for every result
    while (pend_q.size() > 0 || in_tvalid) @(posedge clk);
    while (conv_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (conv_expect_q.size() > 0) begin
      err_cnt = err_cnt + conv_expect_q.size();
      $display("%0d results never arrived", conv_expect_q.size());
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tcconv_pkg.sv
hw/rtl/thermocouple_table_convert_top.sv
dv/tb_top.sv
